>>> sv/smbps_pkg.sv
`timescale 1ns / 1ps

package smbps_pkg;

    typedef enum logic [2:0] {
        KIND_BONE    = 3'd0,
        KIND_VERTEX  = 3'd1,
        KIND_TRI     = 3'd2,
        KIND_TOO     = 3'd3,
        KIND_NOSPLIT = 3'd4
    } t_kind;

    localparam logic [7:0] CFG_BONE_LIMIT = 8'd0;
    localparam logic [7:0] CFG_SOFT       = 8'd1;
    localparam logic [7:0] BONE_FLOOR     = 8'd3;

    typedef struct packed {
        logic       clear;
        logic       clr_b;
        logic       we_v;
        logic       we_b;
        logic       cap_v;
        logic [1:0] cap_v_idx;
        logic       cap_b;
        logic [3:0] cap_b_idx;
        logic       cap_b_cnt;
    } t_ctl;

endpackage

>>> sv/skinned_mesh_bone_palette_splitter_unit.sv
`timescale 1ns / 1ps

// Splits a skinned mesh into bone palettes, one triangle item at a time.
// Triangles enter on the input channel (i_in_valid / o_in_ready) and results
// leave on the output channel (o_out_valid / i_out_ready), one per cycle at
// most, with o_last set on the final result of a triangle. Configuration is
// written through i_cfg_valid / o_cfg_ready with a register index and data.
// Each split is one cell of a chain that holds its own vertex and bone maps.
// A triangle first looks up its vertices and bones in the maps of all cells in
// parallel (ST_READ), lets the reads settle (ST_WAIT) and chooses a split
// (ST_DECIDE). A triangle that joins or opens a split then walks all 9 bone
// slots (ST_BONE) and the 3 vertices (ST_VERT), and ends with the triangle
// result (ST_TRI); the next item is taken once the block is idle again. A
// triangle whose vertices all sit in one split skips the bone walk; an error
// result skips both walks.
// After reset the block clears every map, one row per cycle, over
// max(MAX_VERTICES, SOURCE_BONES) rows, and takes no item until then.
// When the receiver stalls, the result stays in the output register and the
// block waits; the next triangle is taken only after the last result leaves
// the work sequencer.

module skinned_mesh_bone_palette_splitter_unit #(
    parameter int MAX_SPLITS   = 8,
    parameter int MAX_VERTICES = 4096,
    parameter int SOURCE_BONES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_vertex_a,
    input  logic [11:0] i_vertex_b,
    input  logic [11:0] i_vertex_c,
    input  logic [7:0]  i_bone_a0,
    input  logic [7:0]  i_bone_a1,
    input  logic [7:0]  i_bone_a2,
    input  logic [7:0]  i_bone_b0,
    input  logic [7:0]  i_bone_b1,
    input  logic [7:0]  i_bone_b2,
    input  logic [7:0]  i_bone_c0,
    input  logic [7:0]  i_bone_c1,
    input  logic [7:0]  i_bone_c2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_split_id,
    output logic [11:0] o_new_slot,
    output logic [11:0] o_source_index,
    output logic [11:0] o_local_a,
    output logic [11:0] o_local_b,
    output logic [11:0] o_local_c,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int BW  = $clog2(SOURCE_BONES);
    localparam int SOW = $clog2(MAX_SPLITS + 1);
    localparam int CD  = (MAX_VERTICES > SOURCE_BONES) ? MAX_VERTICES : SOURCE_BONES;
    localparam int CW  = $clog2(CD);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_DECIDE, ST_BONE, ST_VERT, ST_TRI
    } t_state;

    t_state r_state;
    logic [CW-1:0]  r_clr;
    logic [7:0]     r_limit;
    logic           r_soft;
    logic [SOW-1:0] r_open;
    logic [SOW-1:0] r_sel;
    logic [3:0]     r_idx;
    logic           r_cap;
    logic [3:0]     r_cidx;
    logic [VW-1:0]  r_v [3];
    logic [BW-1:0]  r_b [9];
    logic [8:0]     r_bcnt;
    logic [VW-1:0]  r_loc [3];
    logic           r_err;
    smbps_pkg::t_kind r_ekind;
    logic           r_ovalid;
    smbps_pkg::t_kind r_okind;
    logic [2:0]     r_osid;
    logic [11:0]    r_oslot;
    logic [11:0]    r_osrc;
    logic [11:0]    r_ola;
    logic [11:0]    r_olb;
    logic [11:0]    r_olc;
    logic           r_olast;

    smbps_pkg::t_ctl ctl;
    logic [VW-1:0]  vaddr;
    logic [BW-1:0]  baddr;
    logic [7:0]     eff_limit;
    logic           out_free;
    logic           emit;
    logic [11:0]    in_v [3];
    logic [7:0]     in_b [9];
    logic [VW-1:0]  sat_v [3];
    logic [BW-1:0]  sat_b [9];
    logic [8:0]     active;
    logic [8:0]     cnt;

    logic [MAX_SPLITS:0] hit_ch;
    logic [MAX_SPLITS:0] fit_ch;
    logic [MAX_SPLITS-1:0] hit_first;
    logic [MAX_SPLITS-1:0] fit_first;
    logic [MAX_SPLITS-1:0] c_over;
    logic [8:0]            c_bmiss  [MAX_SPLITS];
    logic [2:0]            c_vvalid [MAX_SPLITS];
    logic [2:0][VW-1:0]    c_vslot  [MAX_SPLITS];
    logic [VW:0]           c_vused  [MAX_SPLITS];
    logic [BW:0]           c_bused  [MAX_SPLITS];

    logic [SOW-1:0] m_idx;
    logic [SOW-1:0] hit_idx;
    logic [SOW-1:0] fit_idx;
    logic           s_over;
    logic [8:0]     s_bmiss;
    logic [2:0]     s_vvalid;
    logic [2:0][VW-1:0] s_vslot;
    logic [VW:0]    s_vused;
    logic [BW:0]    s_bused;

    logic [1:0]     k;
    logic           vdup;
    logic           add_v;
    logic [VW-1:0]  loc_k;

    assign in_v = '{i_vertex_a, i_vertex_b, i_vertex_c};
    assign in_b = '{i_bone_a0, i_bone_a1, i_bone_a2, i_bone_b0, i_bone_b1, i_bone_b2,
                    i_bone_c0, i_bone_c1, i_bone_c2};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_v[i] = (17'(in_v[i]) >= 17'(MAX_VERTICES)) ? VW'(MAX_VERTICES - 1)
                                                          : VW'(in_v[i]);
        end
        for (int i = 0; i < 9; i++) begin
            sat_b[i] = (9'(in_b[i]) >= 9'(SOURCE_BONES)) ? BW'(SOURCE_BONES - 1)
                                                        : BW'(in_b[i]);
            active[i] = r_soft || ((i % 3) == 0);
        end
        for (int i = 0; i < 9; i++) begin
            cnt[i] = active[i];
            for (int j = 0; j < i; j++) begin
                if (active[j] && (sat_b[j] == sat_b[i])) begin
                    cnt[i] = 1'b0;
                end
            end
        end
    end

    assign eff_limit   = (r_limit < smbps_pkg::BONE_FLOOR) ? smbps_pkg::BONE_FLOOR : r_limit;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign hit_ch[0] = 1'b0;
    assign fit_ch[0] = 1'b0;

    for (genvar g = 0; g < MAX_SPLITS; g++) begin : g_cell
        smbps_cell #(
            .MAX_SPLITS   (MAX_SPLITS),
            .MAX_VERTICES (MAX_VERTICES),
            .SOURCE_BONES (SOURCE_BONES),
            .IDX          (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_wsel      (r_sel),
            .i_open      (r_open),
            .i_limit     (eff_limit),
            .i_vaddr     (vaddr),
            .i_baddr     (baddr),
            .i_hit_prev  (hit_ch[g]),
            .i_fit_prev  (fit_ch[g]),
            .o_hit_any   (hit_ch[g+1]),
            .o_fit_any   (fit_ch[g+1]),
            .o_hit_first (hit_first[g]),
            .o_fit_first (fit_first[g]),
            .o_over      (c_over[g]),
            .o_bmiss     (c_bmiss[g]),
            .o_vvalid    (c_vvalid[g]),
            .o_vslot     (c_vslot[g]),
            .o_vused     (c_vused[g]),
            .o_bused     (c_bused[g])
        );
    end

    assign m_idx = (r_state == ST_DECIDE) ? r_open : r_sel;

    always_comb begin
        hit_idx  = '0;
        fit_idx  = '0;
        s_over   = 1'b0;
        s_bmiss  = '0;
        s_vvalid = '0;
        s_vslot  = '0;
        s_vused  = '0;
        s_bused  = '0;
        for (int i = 0; i < MAX_SPLITS; i++) begin
            if (hit_first[i]) begin
                hit_idx = SOW'(i);
            end
            if (fit_first[i]) begin
                fit_idx = SOW'(i);
            end
            if (SOW'(i) == m_idx) begin
                s_over   = c_over[i];
                s_bmiss  = c_bmiss[i];
                s_vvalid = c_vvalid[i];
                s_vslot  = c_vslot[i];
                s_vused  = c_vused[i];
                s_bused  = c_bused[i];
            end
        end
    end

    assign k = r_idx[1:0];

    always_comb begin
        vdup  = 1'b0;
        loc_k = s_vslot[k];
        if ((k == 2'd1) && (r_v[1] == r_v[0])) begin
            vdup  = 1'b1;
            loc_k = r_loc[0];
        end else if ((k == 2'd2) && (r_v[2] == r_v[0])) begin
            vdup  = 1'b1;
            loc_k = r_loc[0];
        end else if ((k == 2'd2) && (r_v[2] == r_v[1])) begin
            vdup  = 1'b1;
            loc_k = r_loc[1];
        end
        add_v = !vdup && !s_vvalid[k];
        if (add_v) begin
            loc_k = s_vused[VW-1:0];
        end
    end

    assign emit = out_free && (((r_state == ST_BONE) && s_bmiss[r_idx]) ||
                               ((r_state == ST_VERT) && add_v) ||
                               (r_state == ST_TRI));

    always_comb begin
        ctl           = '0;
        vaddr         = '0;
        baddr         = '0;
        ctl.cap_v     = r_cap && (r_cidx < 4'd3);
        ctl.cap_v_idx = r_cidx[1:0];
        ctl.cap_b     = r_cap;
        ctl.cap_b_idx = r_cidx;
        ctl.cap_b_cnt = r_bcnt[r_cidx];
        case (r_state)
            ST_CLEAR: begin
                ctl.clear = 1'b1;
                ctl.clr_b = ({1'b0, r_clr} < (CW + 1)'(SOURCE_BONES));
                vaddr     = VW'(r_clr);
                baddr     = BW'(r_clr);
            end
            ST_READ: begin
                vaddr = r_v[(r_idx < 4'd3) ? r_idx[1:0] : 2'd0];
                baddr = r_b[r_idx];
            end
            ST_BONE: begin
                baddr    = r_b[r_idx];
                ctl.we_b = s_bmiss[r_idx] && out_free;
            end
            ST_VERT: begin
                vaddr    = r_v[k];
                ctl.we_v = add_v && out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_limit  <= 8'd15;
            r_soft   <= 1'b1;
            r_open   <= '0;
            r_sel    <= '0;
            r_idx    <= '0;
            r_cap    <= 1'b0;
            r_cidx   <= '0;
            r_err    <= 1'b0;
            r_ekind  <= smbps_pkg::KIND_TRI;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == smbps_pkg::CFG_BONE_LIMIT) begin
                    r_limit <= i_cfg_data;
                end else if (i_cfg_index == smbps_pkg::CFG_SOFT) begin
                    r_soft <= i_cfg_data[0];
                end
            end
            r_ovalid <= emit || (r_ovalid && !i_out_ready);
            r_cap  <= (r_state == ST_READ);
            r_cidx <= r_idx;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CW'(CD - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_v     <= sat_v;
                        r_b     <= sat_b;
                        r_bcnt  <= cnt;
                        r_idx   <= '0;
                        r_err   <= 1'b0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == 4'd8) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_idx <= '0;
                    if (hit_ch[MAX_SPLITS]) begin
                        r_sel   <= hit_idx;
                        r_state <= ST_VERT;
                    end else if (fit_ch[MAX_SPLITS]) begin
                        r_sel   <= fit_idx;
                        r_state <= ST_BONE;
                    end else if (r_open == SOW'(MAX_SPLITS)) begin
                        r_err   <= 1'b1;
                        r_ekind <= smbps_pkg::KIND_NOSPLIT;
                        r_state <= ST_TRI;
                    end else if (s_over) begin
                        r_err   <= 1'b1;
                        r_ekind <= smbps_pkg::KIND_TOO;
                        r_state <= ST_TRI;
                    end else begin
                        r_sel   <= r_open;
                        r_open  <= r_open + 1'b1;
                        r_state <= ST_BONE;
                    end
                end
                ST_BONE: begin
                    if (!s_bmiss[r_idx] || out_free) begin
                        if (s_bmiss[r_idx]) begin
                            r_okind  <= smbps_pkg::KIND_BONE;
                            r_osid   <= 3'(r_sel);
                            r_oslot  <= 12'(s_bused);
                            r_osrc   <= 12'(r_b[r_idx]);
                            r_ola    <= '0;
                            r_olb    <= '0;
                            r_olc    <= '0;
                            r_olast  <= 1'b0;
                        end
                        if (r_idx == 4'd8) begin
                            r_idx   <= '0;
                            r_state <= ST_VERT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_VERT: begin
                    if (!add_v || out_free) begin
                        if (add_v) begin
                            r_okind  <= smbps_pkg::KIND_VERTEX;
                            r_osid   <= 3'(r_sel);
                            r_oslot  <= 12'(s_vused[VW-1:0]);
                            r_osrc   <= 12'(r_v[k]);
                            r_ola    <= '0;
                            r_olb    <= '0;
                            r_olc    <= '0;
                            r_olast  <= 1'b0;
                        end
                        r_loc[k] <= loc_k;
                        if (k == 2'd2) begin
                            r_state <= ST_TRI;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_TRI: begin
                    if (out_free) begin
                        r_oslot  <= '0;
                        r_osrc   <= '0;
                        r_olast  <= 1'b1;
                        if (r_err) begin
                            r_okind <= r_ekind;
                            r_osid  <= '0;
                            r_ola   <= '0;
                            r_olb   <= '0;
                            r_olc   <= '0;
                        end else begin
                            r_okind <= smbps_pkg::KIND_TRI;
                            r_osid  <= 3'(r_sel);
                            r_ola   <= 12'(r_loc[0]);
                            r_olb   <= 12'(r_loc[1]);
                            r_olc   <= 12'(r_loc[2]);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_okind;
    assign o_split_id     = r_osid;
    assign o_new_slot     = r_oslot;
    assign o_source_index = r_osrc;
    assign o_local_a      = r_ola;
    assign o_local_b      = r_olb;
    assign o_local_c      = r_olc;
    assign o_last         = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= SOW'(MAX_SPLITS))
        else $error("open split count above limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_READ))
        else $error("accepted item did not start lookups");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_kind == smbps_pkg::KIND_TRI ||
                                     o_kind == smbps_pkg::KIND_TOO ||
                                     o_kind == smbps_pkg::KIND_NOSPLIT))
        else $error("last flag on an add result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.we_b || ctl.we_v) |-> (r_sel < r_open))
        else $error("map write to a split that is not open");

endmodule

>>> sv/smbps_cell.sv
`timescale 1ns / 1ps

module smbps_cell #(
    parameter int MAX_SPLITS   = 8,
    parameter int MAX_VERTICES = 4096,
    parameter int SOURCE_BONES = 256,
    parameter int IDX          = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  smbps_pkg::t_ctl                             i_ctl,
    input  logic [$clog2(MAX_SPLITS+1)-1:0]             i_wsel,
    input  logic [$clog2(MAX_SPLITS+1)-1:0]             i_open,
    input  logic [7:0]                                  i_limit,
    input  logic [$clog2(MAX_VERTICES)-1:0]             i_vaddr,
    input  logic [$clog2(SOURCE_BONES)-1:0]             i_baddr,
    input  logic                                        i_hit_prev,
    input  logic                                        i_fit_prev,
    output logic                                        o_hit_any,
    output logic                                        o_fit_any,
    output logic                                        o_hit_first,
    output logic                                        o_fit_first,
    output logic                                        o_over,
    output logic [8:0]                                  o_bmiss,
    output logic [2:0]                                  o_vvalid,
    output logic [2:0][$clog2(MAX_VERTICES)-1:0]        o_vslot,
    output logic [$clog2(MAX_VERTICES):0]               o_vused,
    output logic [$clog2(SOURCE_BONES):0]               o_bused
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int BW  = $clog2(SOURCE_BONES);
    localparam int SOW = $clog2(MAX_SPLITS + 1);
    localparam logic [SOW-1:0] MY = SOW'(IDX);

    logic [VW:0] r_vmem [MAX_VERTICES];
    logic        r_bmem [SOURCE_BONES];
    logic [VW:0] r_vq;
    logic        r_bq;
    logic [VW:0] r_vused;
    logic [BW:0] r_bused;
    logic [2:0]  r_vvalid;
    logic [2:0][VW-1:0] r_vslot;
    logic [8:0]  r_bmiss;

    logic        mine;
    logic        v_we;
    logic        b_we;
    logic [VW:0] v_wdata;
    logic        is_open;
    logic [3:0]  miss;
    logic [9:0]  need;
    logic        hit;
    logic        fit;

    assign mine    = (i_wsel == MY);
    assign v_we    = i_ctl.clear | (i_ctl.we_v & mine);
    assign b_we    = (i_ctl.clear & i_ctl.clr_b) | (i_ctl.we_b & mine);
    assign v_wdata = i_ctl.clear ? '0 : {1'b1, r_vused[VW-1:0]};

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[i_vaddr] <= v_wdata;
        end
        r_vq <= r_vmem[i_vaddr];
        if (b_we) begin
            r_bmem[i_baddr] <= !i_ctl.clear;
        end
        r_bq <= r_bmem[i_baddr];
        if (i_ctl.cap_v) begin
            r_vvalid[i_ctl.cap_v_idx] <= r_vq[VW];
            r_vslot[i_ctl.cap_v_idx]  <= r_vq[VW-1:0];
        end
        if (i_ctl.cap_b) begin
            r_bmiss[i_ctl.cap_b_idx] <= i_ctl.cap_b_cnt & !r_bq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vused <= '0;
            r_bused <= '0;
        end else begin
            if (i_ctl.we_v && mine) begin
                r_vused <= r_vused + 1'b1;
            end
            if (i_ctl.we_b && mine) begin
                r_bused <= r_bused + 1'b1;
            end
        end
    end

    assign is_open = (MY < i_open);
    assign miss    = 4'($countones(r_bmiss));
    assign need    = 10'(r_bused) + 10'(miss);
    assign hit     = is_open & (&r_vvalid);
    assign fit     = is_open & (need <= 10'(i_limit));

    assign o_hit_any   = i_hit_prev | hit;
    assign o_fit_any   = i_fit_prev | fit;
    assign o_hit_first = hit & !i_hit_prev;
    assign o_fit_first = fit & !i_fit_prev;
    assign o_over      = (10'(miss) > 10'(i_limit));
    assign o_bmiss     = r_bmiss;
    assign o_vvalid    = r_vvalid;
    assign o_vslot     = r_vslot;
    assign o_vused     = r_vused;
    assign o_bused     = r_bused;

endmodule

>>> sim/skinned_mesh_bone_palette_splitter_unit_tb.sv
`timescale 1ns / 1ps

module skinned_mesh_bone_palette_splitter_unit_tb;

    localparam int NSPLIT = 8;
    localparam int NVERT  = 4096;
    localparam int NBONE  = 256;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [11:0] v [3];
        logic [7:0]  b [9];
    } t_tri;

    typedef struct {
        smbps_pkg::t_kind kind;
        logic [2:0]  sid;
        logic [11:0] slot, src, la, lb, lc;
        logic        last;
    } t_res;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [11:0] i_vertex_a, i_vertex_b, i_vertex_c;
    logic [7:0]  i_bone_a0, i_bone_a1, i_bone_a2, i_bone_b0, i_bone_b1, i_bone_b2;
    logic [7:0]  i_bone_c0, i_bone_c1, i_bone_c2;
    logic        o_out_valid, i_out_ready;
    logic [2:0]  o_kind, o_split_id;
    logic [11:0] o_new_slot, o_source_index, o_local_a, o_local_b, o_local_c;
    logic        o_last;
    logic        i_cfg_valid, o_cfg_ready;
    logic [7:0]  i_cfg_index, i_cfg_data;

    skinned_mesh_bone_palette_splitter_unit u_dut (.*);

    // Predictor state: maps hold slot + 1, zero means absent.
    int unsigned vmap [NSPLIT][NVERT];
    int unsigned bmap [NSPLIT][NBONE];
    int unsigned vused [NSPLIT];
    int unsigned bused [NSPLIT];
    int unsigned nopen;
    int unsigned lim_reg;
    bit          soft_reg;

    t_tri pending_tris [$];
    t_res expected_results [$];
    int   errors = 0;
    longint cycles = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    function automatic void queue_tri(t_tri t);
        pending_tris = {pending_tris, t};
    endfunction

    function automatic void push_res(smbps_pkg::t_kind k, int unsigned s, int unsigned slot,
                                     int unsigned src, int unsigned a, int unsigned b,
                                     int unsigned c);
        t_res r;
        r.kind = k; r.sid = s[2:0]; r.slot = slot[11:0]; r.src = src[11:0];
        r.la = a[11:0]; r.lb = b[11:0]; r.lc = c[11:0]; r.last = 1'b0;
        expected_results = {expected_results, r};
    endfunction

    function automatic int unsigned count_missing(int unsigned s, int unsigned bl [9],
                                                  int nb);
        int unsigned m = 0;
        bit dup;
        for (int i = 0; i < nb; i++) begin
            dup = 0;
            for (int j = 0; j < i; j++) if (bl[j] == bl[i]) dup = 1;
            if (!dup && bmap[s][bl[i]] == 0) m++;
        end
        return m;
    endfunction

    function automatic void place_tri(int unsigned s, int unsigned vv [3],
                                      int unsigned bl [9], int nb);
        for (int i = 0; i < nb; i++) begin
            if (bmap[s][bl[i]] == 0) begin
                bmap[s][bl[i]] = bused[s] + 1;
                push_res(smbps_pkg::KIND_BONE, s, bused[s], bl[i], 0, 0, 0);
                bused[s]++;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (vmap[s][vv[i]] == 0) begin
                vmap[s][vv[i]] = vused[s] + 1;
                push_res(smbps_pkg::KIND_VERTEX, s, vused[s], vv[i], 0, 0, 0);
                vused[s]++;
            end
        end
        push_res(smbps_pkg::KIND_TRI, s, 0, 0, vmap[s][vv[0]] - 1, vmap[s][vv[1]] - 1,
                 vmap[s][vv[2]] - 1);
    endfunction

    function automatic void predict_split(t_tri t);
        int unsigned vv [3];
        int unsigned bl [9];
        int nb = 0;
        int unsigned lim;
        bit placed = 0;
        lim = lim_reg < 3 ? 3 : lim_reg;
        for (int i = 0; i < 3; i++) vv[i] = 32'(t.v[i]);
        for (int i = 0; i < 9; i++) begin
            if (soft_reg || (i % 3) == 0) begin
                bl[nb] = 32'(t.b[i]);
                nb++;
            end
        end
        for (int unsigned s = 0; s < nopen && !placed; s++) begin
            if (vmap[s][vv[0]] != 0 && vmap[s][vv[1]] != 0 && vmap[s][vv[2]] != 0) begin
                push_res(smbps_pkg::KIND_TRI, s, 0, 0, vmap[s][vv[0]] - 1,
                         vmap[s][vv[1]] - 1, vmap[s][vv[2]] - 1);
                placed = 1;
            end
        end
        for (int unsigned s = 0; s < nopen && !placed; s++) begin
            if (bused[s] + count_missing(s, bl, nb) <= lim) begin
                place_tri(s, vv, bl, nb);
                placed = 1;
            end
        end
        if (!placed) begin
            if (nopen >= NSPLIT) push_res(smbps_pkg::KIND_NOSPLIT, 0, 0, 0, 0, 0, 0);
            else if (count_missing(nopen, bl, nb) > lim)
                push_res(smbps_pkg::KIND_TOO, 0, 0, 0, 0, 0, 0);
            else begin
                nopen++;
                place_tri(nopen - 1, vv, bl, nb);
            end
        end
        expected_results[$].last = 1'b1;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Input driver.
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_vertex_a <= '0;
            i_vertex_b <= '0;
            i_vertex_c <= '0;
            i_bone_a0 <= '0;
            i_bone_a1 <= '0;
            i_bone_a2 <= '0;
            i_bone_b0 <= '0;
            i_bone_b1 <= '0;
            i_bone_b2 <= '0;
            i_bone_c0 <= '0;
            i_bone_c1 <= '0;
            i_bone_c2 <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_split(pending_tris.pop_front());
                in_gap = int'($urandom_range(0, 15));
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 0;
                end else if (pending_tris.size() > 0) begin
                    i_in_valid <= 1;
                    i_vertex_a <= pending_tris[0].v[0];
                    i_vertex_b <= pending_tris[0].v[1];
                    i_vertex_c <= pending_tris[0].v[2];
                    i_bone_a0 <= pending_tris[0].b[0];
                    i_bone_a1 <= pending_tris[0].b[1];
                    i_bone_a2 <= pending_tris[0].b[2];
                    i_bone_b0 <= pending_tris[0].b[3];
                    i_bone_b1 <= pending_tris[0].b[4];
                    i_bone_b2 <= pending_tris[0].b[5];
                    i_bone_c0 <= pending_tris[0].b[6];
                    i_bone_c1 <= pending_tris[0].b[7];
                    i_bone_c2 <= pending_tris[0].b[8];
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // Output monitor with random stalls.
    int out_gap = 0;
    always @(posedge i_clk) begin
        t_res e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("skinned_mesh_bone_palette_splitter_unit_tb failed");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d", o_kind));
            end else begin
                e = expected_results.pop_front();
                if (o_kind !== e.kind || o_split_id !== e.sid || o_new_slot !== e.slot ||
                    o_source_index !== e.src || o_local_a !== e.la || o_local_b !== e.lb ||
                    o_local_c !== e.lc || o_last !== e.last)
                    report($sformatf(
                        {"got k%0d s%0d n%0d x%0d %0d/%0d/%0d l%0d",
                         " exp k%0d s%0d n%0d x%0d %0d/%0d/%0d l%0d"},
                        o_kind, o_split_id, o_new_slot, o_source_index, o_local_a,
                        o_local_b, o_local_c, o_last, e.kind, e.sid, e.slot, e.src,
                        e.la, e.lb, e.lc, e.last));
            end
            out_gap = int'($urandom_range(0, 15));
        end
        if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == smbps_pkg::CFG_BONE_LIMIT) lim_reg = 32'(val);
        else if (idx == smbps_pkg::CFG_SOFT) soft_reg = val[0];
    endtask

    task automatic wait_idle();
        while (pending_tris.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    function automatic t_tri mk_tri(int unsigned va, int unsigned vb, int unsigned vc,
                                    int unsigned bb);
        t_tri t;
        t.v[0] = 12'(va); t.v[1] = 12'(vb); t.v[2] = 12'(vc);
        for (int i = 0; i < 9; i++) t.b[i] = 8'(bb + 32'(i));
        return t;
    endfunction

    // Mostly local meshes so triangles reuse vertices and bones of a split.
    function automatic t_tri rand_tri(int unsigned vbase, int unsigned bbase, int spread);
        t_tri t;
        int mode = int'($urandom_range(0, 9));
        for (int i = 0; i < 3; i++)
            t.v[i] = (mode == 0) ? 12'($urandom()) : 12'(vbase + $urandom_range(0, 40));
        for (int i = 0; i < 9; i++)
            t.b[i] = (mode == 0) ? 8'($urandom()) :
                                   8'(bbase + $urandom_range(0, 32'(spread)));
        return t;
    endfunction

    initial begin
        t_tri t;
        int unsigned vbase, bbase;
        int lims [6] = '{0, 3, 8, 15, 40, 255};
        i_rst_n = 0; i_cfg_valid = 0;
        i_cfg_index = 0; i_cfg_data = 0;
        nopen = 0; lim_reg = 15; soft_reg = 1;
        for (int s = 0; s < NSPLIT; s++) begin
            vused[s] = 0;
            bused[s] = 0;
            for (int v = 0; v < NVERT; v++) vmap[s][v] = 0;
            for (int b = 0; b < NBONE; b++) bmap[s][b] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part at reset settings, then hard mode and the smallest limit.
        queue_tri(mk_tri(0, 4095, 2048, 0));
        queue_tri(mk_tri(0, 4095, 2048, 0));
        queue_tri(mk_tri(5, 5, 5, 247));
        t = mk_tri(1, 2, 3, 0);
        foreach (t.b[i]) t.b[i] = 8'hff;
        queue_tri(t);
        queue_tri(mk_tri(4095, 6, 7, 100));
        queue_tri(mk_tri(10, 11, 12, 120));
        wait_idle();
        write_reg(smbps_pkg::CFG_BONE_LIMIT, 8'd0);
        write_reg(smbps_pkg::CFG_SOFT, 8'd0);
        queue_tri(mk_tri(20, 21, 22, 30));
        queue_tri(mk_tri(23, 24, 25, 60));
        queue_tri(mk_tri(20, 21, 22, 200));
        for (int i = 0; i < 8; i++)
            queue_tri(mk_tri(32'(30 + i), 32'(40 + i), 50, 32'(10 * i)));
        wait_idle();
        write_reg(smbps_pkg::CFG_SOFT, 8'd1);
        queue_tri(mk_tri(60, 61, 62, 0));
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(smbps_pkg::CFG_BONE_LIMIT, 8'(lims[$urandom_range(0, 5)]));
            if (ph == 11) write_reg(smbps_pkg::CFG_BONE_LIMIT, 8'd255);
            write_reg(smbps_pkg::CFG_SOFT, {7'd0, ph[0]});
            vbase = $urandom_range(0, 4000);
            bbase = $urandom_range(0, 240);
            for (int i = 0; i < 40; i++)
                queue_tri(rand_tri(vbase, bbase, int'($urandom_range(2, 15))));
            wait_idle();
        end
        if (errors == 0) begin
            $display("skinned_mesh_bone_palette_splitter_unit_tb passed");
        end else begin
            $display("skinned_mesh_bone_palette_splitter_unit_tb failed");
        end
        $finish;
    end
endmodule
